// ----- hdl/tdt_pkg.sv -----
// ----------------------------------------------------------------------------
// tdt_pkg: shared types and codes for the task delay timer table
// Command, status and sequencer state codes used across the block.
// ----------------------------------------------------------------------------
package tdt_pkg;

   localparam logic [2:0] CMD_REGISTER  = 3'd0;
   localparam logic [2:0] CMD_REMOVE    = 3'd1;
   localparam logic [2:0] CMD_SET_SPLIT = 3'd2;
   localparam logic [2:0] CMD_SET_TOTAL = 3'd3;
   localparam logic [2:0] CMD_TICK      = 3'd4;

   localparam logic [1:0] ST_DONE      = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [1:0] ST_EXPIRED   = 2'd3;

   localparam int MAX_RESULTS = 16;

   typedef enum logic [3:0] {
      S_IDLE,
      S_FIND_RD,
      S_FIND_CHK,
      S_DIV,
      S_MOVE_RD,
      S_MOVE_WR,
      S_TICK_RD,
      S_TICK_WR,
      S_OUT
   } state_type;

endpackage

// ----- hdl/tdt_divider.sv -----
// ----------------------------------------------------------------------------
// tdt_divider: 32 by 16 bit restoring divider
// One quotient bit per cycle; done pulses when the last quotient bit is in place.
// ----------------------------------------------------------------------------
module tdt_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [15:0] divisor,
   output logic        done,
   output logic [31:0] quotient,
   output logic [15:0] remainder
);

   logic [31:0] q_ff, q_in;
   logic [16:0] r_ff, r_in;
   logic [15:0] d_ff, d_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [16:0] trial;

   always_comb begin
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {r_ff[15:0], q_ff[31]};
      if (start) begin
         q_in    = dividend;
         r_in    = '0;
         d_in    = divisor;
         cnt_in  = 6'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in next dividend bit, subtract when it fits
         if (trial >= {1'b0, d_ff}) begin
            r_in = trial - {1'b0, d_ff};
            q_in = {q_ff[30:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      r_ff   <= r_in;
      d_ff   <= d_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = q_ff;
   assign remainder = r_ff[15:0];

endmodule

// ----- hdl/task_delay_timer_table.sv -----
// ----------------------------------------------------------------------------
// task_delay_timer_table: ordered table of task delay timers
// Register, remove, delay setting and tick countdown over a slot memory.
// ----------------------------------------------------------------------------
// One item is taken at a time; req_ready is low while it is worked on. The
// slot memory has separate read and write ports with registered read data,
// so a slot that is searched, moved or ticked is read in one state and
// written or checked in the next. Remove, set split and set total search
// the table first, up to the match; remove then moves every later slot
// down, and set total waits on the bit-serial divider. A tick walks all
// occupied slots and holds while an expiry item waits on the result
// channel. Each result item sits in an output register until taken. The
// memory needs no clearing pass: only slots below the fill count are ever
// used.
// ----------------------------------------------------------------------------
module task_delay_timer_table #(
   parameter int TABLE_DEPTH  = 16,
   parameter int TASK_ID_BITS = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [2:0]              req_command,
   input  logic [TASK_ID_BITS-1:0] req_task_id,
   input  logic [31:0]             req_delay_count,
   input  logic [15:0]             req_delay_fraction,
   input  logic [15:0]             req_elapsed,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [TASK_ID_BITS-1:0] rsp_result_task,
   output logic [1:0]              rsp_status,
   output logic                    rsp_last,
   input  logic                    csr_write,
   input  logic [15:0]             csr_wdata
);

   localparam int IDX_BITS = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(TABLE_DEPTH + 1);
   localparam int ENT_BITS = TASK_ID_BITS + 32 + 16 + 1;
   localparam int RES_BITS = $clog2(tdt_pkg::MAX_RESULTS + 1);

   // slot memory: {task, ticks, fraction, ready}
   logic [ENT_BITS-1:0] mem [TABLE_DEPTH];
   logic [ENT_BITS-1:0] rd_data_ff;
   logic                mem_we;
   logic [IDX_BITS-1:0] mem_waddr, mem_raddr;
   logic [ENT_BITS-1:0] mem_wdata;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
   end

   logic [TASK_ID_BITS-1:0] rd_task;
   logic [31:0]             rd_ticks;
   logic [15:0]             rd_frac;
   logic                    rd_ready;
   assign {rd_task, rd_ticks, rd_frac, rd_ready} = rd_data_ff;

   tdt_pkg::state_type      state_ff, state_in;
   logic [15:0]             tick_len_ff;
   logic [CNT_BITS-1:0]     count_ff, count_in;
   logic [CNT_BITS-1:0]     idx_ff, idx_in;
   logic [2:0]              cmd_ff, cmd_in;
   logic [TASK_ID_BITS-1:0] task_ff, task_in;
   logic [31:0]             dcount_ff, dcount_in;
   logic [15:0]             dfrac_ff, dfrac_in;
   logic [15:0]             elapsed_ff, elapsed_in;
   logic [RES_BITS-1:0]     nres_ff, nres_in;
   logic                    ovalid_ff, ovalid_in;
   logic [TASK_ID_BITS-1:0] otask_ff, otask_in;
   logic [1:0]              ostat_ff, ostat_in;
   logic                    olast_ff, olast_in;
   logic                    div_start, div_done;
   logic [31:0]             div_q;
   logic [15:0]             div_r;
   logic [15:0]             eff_tick;
   logic [15:0]             e_clamp;

   assign eff_tick = (tick_len_ff == 16'd0) ? 16'd1 : tick_len_ff;
   assign e_clamp  = (elapsed_ff > eff_tick) ? eff_tick : elapsed_ff;

   tdt_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (dcount_ff),
      .divisor   (eff_tick),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   // tick countdown arithmetic on the slot just read
   logic [31:0] t_ticks;
   logic [15:0] t_frac;
   logic        t_exp, t_wait;
   always_comb begin
      t_ticks = rd_ticks;
      t_frac  = rd_frac;
      t_exp   = 1'b0;
      t_wait  = !rd_ready && !(rd_ticks == 32'd0 && rd_frac == 16'd0);
      if (e_clamp >= rd_frac) begin
         if (rd_ticks == 32'd0) begin
            t_exp = 1'b1;
         end else begin
            t_ticks = rd_ticks - 32'd1;
            t_frac  = eff_tick - (e_clamp - rd_frac);
            t_exp   = (t_ticks == 32'd0) && (t_frac == 16'd0);
         end
      end else begin
         t_frac = rd_frac - e_clamp;
      end
   end

   // true when a later occupied slot will still be visited
   logic more_slots;
   assign more_slots = (idx_ff + CNT_BITS'(1)) < count_ff;

   logic out_free;
   assign out_free = !ovalid_ff || rsp_ready;

   // lookahead for the tick's last flag: an expiry item is held until the
   // walk shows whether another expiry follows, so last is patched below
   logic                    hold_ff, hold_in;
   logic [TASK_ID_BITS-1:0] htask_ff;

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      cmd_in     = cmd_ff;
      task_in    = task_ff;
      dcount_in  = dcount_ff;
      dfrac_in   = dfrac_ff;
      elapsed_in = elapsed_ff;
      nres_in    = nres_ff;
      ovalid_in  = ovalid_ff && !rsp_ready;
      otask_in   = otask_ff;
      ostat_in   = ostat_ff;
      olast_in   = olast_ff;
      mem_we     = 1'b0;
      mem_waddr  = idx_ff[IDX_BITS-1:0];
      mem_raddr  = idx_ff[IDX_BITS-1:0];
      mem_wdata  = rd_data_ff;
      div_start  = 1'b0;
      req_ready  = 1'b0;

      unique case (state_ff)
         tdt_pkg::S_IDLE: begin
            req_ready = out_free;
            if (req_valid && out_free) begin
               cmd_in     = req_command;
               task_in    = req_task_id;
               dcount_in  = req_delay_count;
               dfrac_in   = req_delay_fraction;
               elapsed_in = req_elapsed;
               idx_in     = '0;
               nres_in    = '0;
               unique case (req_command) inside
                  tdt_pkg::CMD_REGISTER: begin
                     state_in = tdt_pkg::S_OUT;
                  end
                  tdt_pkg::CMD_REMOVE, tdt_pkg::CMD_SET_SPLIT, tdt_pkg::CMD_SET_TOTAL: begin
                     state_in = tdt_pkg::S_FIND_RD;
                  end
                  tdt_pkg::CMD_TICK: begin
                     state_in = tdt_pkg::S_TICK_RD;
                  end
                  default: begin
                     state_in = tdt_pkg::S_IDLE;
                  end
               endcase
            end
         end
         tdt_pkg::S_OUT: begin
            // register command: append or report full
            if (out_free) begin
               ovalid_in = 1'b1;
               otask_in  = task_ff;
               olast_in  = 1'b1;
               if (count_ff >= CNT_BITS'(TABLE_DEPTH)) begin
                  ostat_in = tdt_pkg::ST_FULL;
               end else begin
                  ostat_in  = tdt_pkg::ST_DONE;
                  mem_we    = 1'b1;
                  mem_waddr = count_ff[IDX_BITS-1:0];
                  mem_wdata = {task_ff, 32'd0, 16'd0, 1'b1};
                  count_in  = count_ff + CNT_BITS'(1);
               end
               state_in = tdt_pkg::S_IDLE;
            end
         end
         tdt_pkg::S_FIND_RD: begin
            if (idx_ff >= count_ff) begin
               if (out_free) begin
                  ovalid_in = 1'b1;
                  otask_in  = task_ff;
                  ostat_in  = tdt_pkg::ST_NOT_FOUND;
                  olast_in  = 1'b1;
                  state_in  = tdt_pkg::S_IDLE;
               end
            end else begin
               state_in = tdt_pkg::S_FIND_CHK;
            end
         end
         tdt_pkg::S_FIND_CHK: begin
            if (rd_task == task_ff) begin
               if (cmd_ff == tdt_pkg::CMD_REMOVE) begin
                  state_in = tdt_pkg::S_MOVE_RD;
               end else if (cmd_ff == tdt_pkg::CMD_SET_SPLIT) begin
                  mem_we    = 1'b1;
                  mem_wdata = {rd_task, dcount_ff, dfrac_ff,
                               (dcount_ff == 32'd0 && dfrac_ff == 16'd0)};
                  ovalid_in = 1'b1;
                  otask_in  = task_ff;
                  ostat_in  = tdt_pkg::ST_DONE;
                  olast_in  = 1'b1;
                  state_in  = tdt_pkg::S_IDLE;
               end else begin
                  div_start = 1'b1;
                  dfrac_in  = {16'd0};
                  otask_in  = rd_task;
                  state_in  = tdt_pkg::S_DIV;
               end
            end else begin
               idx_in   = idx_ff + CNT_BITS'(1);
               state_in = tdt_pkg::S_FIND_RD;
            end
         end
         tdt_pkg::S_DIV: begin
            if (div_done) begin
               mem_we    = 1'b1;
               mem_wdata = {otask_ff, div_q, div_r,
                            (div_q == 32'd0 && div_r == 16'd0)};
               ovalid_in = 1'b1;
               otask_in  = task_ff;
               ostat_in  = tdt_pkg::ST_DONE;
               olast_in  = 1'b1;
               state_in  = tdt_pkg::S_IDLE;
            end
         end
         tdt_pkg::S_MOVE_RD: begin
            // read the slot after idx, or finish the compaction
            if (more_slots) begin
               mem_raddr = IDX_BITS'(idx_ff + CNT_BITS'(1));
               state_in  = tdt_pkg::S_MOVE_WR;
            end else begin
               count_in  = count_ff - CNT_BITS'(1);
               ovalid_in = 1'b1;
               otask_in  = task_ff;
               ostat_in  = tdt_pkg::ST_DONE;
               olast_in  = 1'b1;
               state_in  = tdt_pkg::S_IDLE;
            end
         end
         tdt_pkg::S_MOVE_WR: begin
            mem_we   = 1'b1;
            idx_in   = idx_ff + CNT_BITS'(1);
            state_in = tdt_pkg::S_MOVE_RD;
         end
         tdt_pkg::S_TICK_RD: begin
            if (idx_ff >= count_ff) begin
               // hold until the held expiry item can go out
               if (!hold_ff || out_free) begin
                  state_in = tdt_pkg::S_IDLE;
               end
            end else begin
               state_in = tdt_pkg::S_TICK_WR;
            end
         end
         tdt_pkg::S_TICK_WR: begin
            // hold while an expiry item would overwrite a waiting one
            if (!t_wait) begin
               idx_in   = idx_ff + CNT_BITS'(1);
               state_in = tdt_pkg::S_TICK_RD;
            end else if (!t_exp) begin
               mem_we    = 1'b1;
               mem_wdata = {rd_task, t_ticks, t_frac, 1'b0};
               idx_in    = idx_ff + CNT_BITS'(1);
               state_in  = tdt_pkg::S_TICK_RD;
            end else if (out_free) begin
               mem_we    = 1'b1;
               mem_wdata = {rd_task, 32'd0, 16'd0, 1'b1};
               idx_in    = idx_ff + CNT_BITS'(1);
               state_in  = tdt_pkg::S_TICK_RD;
               if (nres_ff < RES_BITS'(tdt_pkg::MAX_RESULTS)) begin
                  ovalid_in = 1'b1;
                  otask_in  = rd_task;
                  ostat_in  = tdt_pkg::ST_EXPIRED;
                  nres_in   = nres_ff + RES_BITS'(1);
                  olast_in  = 1'b1;
               end
            end
         end
         default: begin
            state_in = tdt_pkg::S_IDLE;
         end
      endcase
   end

   // expiry items go through a one-deep hold so last can be set correctly
   logic exp_new;
   assign exp_new = ovalid_in && !(ovalid_ff && !rsp_ready) &&
                    (state_ff == tdt_pkg::S_TICK_WR);

   logic tick_end;
   assign tick_end = (state_ff == tdt_pkg::S_TICK_RD) && (idx_ff >= count_ff) &&
                     (!hold_ff || out_free);

   always_comb begin
      hold_in = hold_ff;
      if (exp_new) begin
         hold_in = 1'b1;
      end else if (tick_end) begin
         hold_in = 1'b0;
      end
   end

   // drive outputs: expiry items are shown from the hold register
   logic show_ff, show_in;
   logic [TASK_ID_BITS-1:0] stask_ff, stask_in;
   logic [1:0]              sstat_ff, sstat_in;
   logic                    slast_ff, slast_in;
   always_comb begin
      show_in  = show_ff && !rsp_ready;
      stask_in = stask_ff;
      sstat_in = sstat_ff;
      slast_in = slast_ff;
      if (exp_new && hold_ff) begin
         show_in  = 1'b1;
         stask_in = htask_ff;
         sstat_in = tdt_pkg::ST_EXPIRED;
         slast_in = 1'b0;
      end else if (tick_end && hold_ff) begin
         show_in  = 1'b1;
         stask_in = htask_ff;
         sstat_in = tdt_pkg::ST_EXPIRED;
         slast_in = 1'b1;
      end else if (ovalid_in && !(ovalid_ff && !rsp_ready) && !exp_new) begin
         show_in  = 1'b1;
         stask_in = otask_in;
         sstat_in = ostat_in;
         slast_in = olast_in;
      end
   end

   always_ff @(posedge clock) begin
      task_ff    <= task_in;
      dcount_ff  <= dcount_in;
      dfrac_ff   <= dfrac_in;
      elapsed_ff <= elapsed_in;
      cmd_ff     <= cmd_in;
      otask_ff   <= otask_in;
      ostat_ff   <= ostat_in;
      olast_ff   <= olast_in;
      stask_ff   <= stask_in;
      sstat_ff   <= sstat_in;
      slast_ff   <= slast_in;
      if (exp_new) begin
         htask_ff <= otask_in;
      end
      if (reset) begin
         state_ff    <= tdt_pkg::S_IDLE;
         tick_len_ff <= 16'd1000;
         count_ff    <= '0;
         idx_ff      <= '0;
         nres_ff     <= '0;
         ovalid_ff   <= 1'b0;
         hold_ff     <= 1'b0;
         show_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         idx_ff    <= idx_in;
         nres_ff   <= nres_in;
         ovalid_ff <= show_in;
         hold_ff   <= hold_in;
         show_ff   <= show_in;
         if (csr_write) begin
            tick_len_ff <= csr_wdata;
         end
      end
   end

   assign rsp_valid       = show_ff;
   assign rsp_result_task = stask_ff;
   assign rsp_status      = sstat_ff;
   assign rsp_last        = slast_ff;

endmodule

// ----- sim/task_delay_timer_table_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// task_delay_timer_table_checker: result predictor and comparator
// Watches both channels, tracks the timer table and compares every result item.
// ----------------------------------------------------------------------------
module task_delay_timer_table_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [2:0]  req_command,
   input  logic [7:0]  req_task_id,
   input  logic [31:0] req_delay_count,
   input  logic [15:0] req_delay_fraction,
   input  logic [15:0] req_elapsed,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [7:0]  rsp_result_task,
   input  logic [1:0]  rsp_status,
   input  logic        rsp_last,
   input  logic        csr_write,
   input  logic [15:0] csr_wdata,
   output int          fail_count,
   output int          pending_count,
   output int          expiry_count
);

   localparam int DEPTH = 16;

   typedef struct packed {
      logic [7:0] task_id;
      logic [1:0] status;
      logic       last;
   } timer_result_type;

   timer_result_type result_queue[$];
   logic [15:0]   tick_len;
   logic [7:0]    tab_task  [DEPTH];
   logic [31:0]   tab_ticks [DEPTH];
   logic [15:0]   tab_frac  [DEPTH];
   logic          tab_ready [DEPTH];
   int            tab_fill;

   assign pending_count = result_queue.size();

   function automatic void push_result(logic [7:0] t, logic [1:0] s, logic l);
      timer_result_type r;
      r.task_id = t;
      r.status  = s;
      r.last    = l;
      result_queue.push_back(r);
   endfunction

   task automatic apply_command(logic [2:0] cmd, logic [7:0] tid, logic [31:0] cnt,
                                logic [15:0] frac, logic [15:0] el);
      logic [31:0] unit;
      logic [31:0] e;
      logic [31:0] rem;
      int          slot;
      int          n;
      bit          hit;
      unit = (tick_len == 0) ? 32'd1 : {16'd0, tick_len};
      slot = -1;
      n    = 0;
      for (int i = 0; i < tab_fill; i++)
         if (slot < 0 && tab_task[i] == tid) slot = i;
      case (cmd) inside
         tdt_pkg::CMD_REGISTER: begin
            if (tab_fill >= DEPTH) begin
               push_result(tid, tdt_pkg::ST_FULL, 1'b1);
            end else begin
               tab_task[tab_fill]  = tid;
               tab_ticks[tab_fill] = '0;
               tab_frac[tab_fill]  = '0;
               tab_ready[tab_fill] = 1'b1;
               tab_fill++;
               push_result(tid, tdt_pkg::ST_DONE, 1'b1);
            end
         end
         tdt_pkg::CMD_REMOVE, tdt_pkg::CMD_SET_SPLIT, tdt_pkg::CMD_SET_TOTAL: begin
            if (slot < 0) begin
               push_result(tid, tdt_pkg::ST_NOT_FOUND, 1'b1);
            end else begin
               if (cmd == tdt_pkg::CMD_REMOVE) begin
                  for (int i = slot; i + 1 < tab_fill; i++) begin
                     tab_task[i]  = tab_task[i+1];
                     tab_ticks[i] = tab_ticks[i+1];
                     tab_frac[i]  = tab_frac[i+1];
                     tab_ready[i] = tab_ready[i+1];
                  end
                  tab_fill--;
               end else begin
                  if (cmd == tdt_pkg::CMD_SET_SPLIT) begin
                     tab_ticks[slot] = cnt;
                     tab_frac[slot]  = frac;
                  end else begin
                     tab_ticks[slot] = cnt / unit;
                     rem             = cnt % unit;
                     tab_frac[slot]  = rem[15:0];
                  end
                  tab_ready[slot] = (tab_ticks[slot] == 0 && tab_frac[slot] == 0);
               end
               push_result(tid, tdt_pkg::ST_DONE, 1'b1);
            end
         end
         tdt_pkg::CMD_TICK: begin
            e = ({16'd0, el} > unit) ? unit : {16'd0, el};
            for (int i = 0; i < tab_fill; i++) begin
               hit = 1'b0;
               if (tab_ready[i] || (tab_ticks[i] == 0 && tab_frac[i] == 0)) continue;
               if (e >= tab_frac[i]) begin
                  if (tab_ticks[i] == 0) begin
                     hit = 1'b1;
                  end else begin
                     rem          = unit - (e - tab_frac[i]);
                     tab_ticks[i] = tab_ticks[i] - 1;
                     tab_frac[i]  = rem[15:0];
                     hit = (tab_ticks[i] == 0 && tab_frac[i] == 0);
                  end
               end else begin
                  tab_frac[i] = tab_frac[i] - e[15:0];
               end
               if (hit) begin
                  tab_ticks[i] = '0;
                  tab_frac[i]  = '0;
                  tab_ready[i] = 1'b1;
                  if (n < tdt_pkg::MAX_RESULTS) begin
                     push_result(tab_task[i], tdt_pkg::ST_EXPIRED, 1'b0);
                     n++;
                  end
               end
            end
            if (n > 0) result_queue[$].last = 1'b1;
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      timer_result_type want;
      if (reset) begin
         tick_len = 16'd1000;
         tab_fill = 0;
         result_queue.delete();
         fail_count   <= 0;
         expiry_count <= 0;
      end else begin
         // check the result side first: an item accepted here came from older requests
         if (rsp_valid && rsp_ready) begin
            if (rsp_status == tdt_pkg::ST_EXPIRED) expiry_count <= expiry_count + 1;
            if (result_queue.size() == 0) begin
               if (fail_count < 10)
                  $display("MISMATCH: unexpected result task=%0d status=%0d last=%0b",
                           rsp_result_task, rsp_status, rsp_last);
               fail_count <= fail_count + 1;
            end else begin
               want = result_queue.pop_front();
               if (want.task_id !== rsp_result_task || want.status !== rsp_status ||
                   want.last !== rsp_last) begin
                  if (fail_count < 10)
                     $display("MISMATCH: expected task=%0d status=%0d last=%0b, got %0d %0d %0b",
                              want.task_id, want.status, want.last,
                              rsp_result_task, rsp_status, rsp_last);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (csr_write) tick_len = csr_wdata;
         if (req_valid && req_ready)
            apply_command(req_command, req_task_id, req_delay_count,
                          req_delay_fraction, req_elapsed);
      end
   end

endmodule

// ----- sim/task_delay_timer_table_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// task_delay_timer_table_tb: stimulus and verdict for the timer table
// Drives directed and random command items with random idling, writes the
// tick length between phases and reports the checker's failure count.
// ----------------------------------------------------------------------------
module task_delay_timer_table_tb;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_command = tdt_pkg::CMD_REGISTER;
   logic [7:0]  req_task_id = '0;
   logic [31:0] req_delay_count = '0;
   logic [15:0] req_delay_fraction = '0;
   logic [15:0] req_elapsed = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_result_task;
   logic [1:0]  rsp_status;
   logic        rsp_last;
   logic        csr_write = 1'b0;
   logic [15:0] csr_wdata = '0;

   int  fail_count;
   int  pending_count;
   int  expiry_count;
   int  items_sent;
   int  rsp_stall = 0;
   bit  hold_off_rsp;
   logic [7:0] known_ids[$];

   always #5 clock = ~clock;

   task_delay_timer_table #(.TABLE_DEPTH(16), .TASK_ID_BITS(8)) dut (.*);

   task_delay_timer_table_checker checker_i (.*);

   // Pick a gap: mostly none or short, now and then long.
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Offer one item and hold it until the block takes it.
   task automatic send_item(logic [2:0] cmd, logic [7:0] tid, logic [31:0] cnt,
                            logic [15:0] frac, logic [15:0] el);
      req_valid          <= 1'b1;
      req_command        <= cmd;
      req_task_id        <= tid;
      req_delay_count    <= cnt;
      req_delay_fraction <= frac;
      req_elapsed        <= el;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      if (cmd == tdt_pkg::CMD_REGISTER) known_ids.push_back(tid);
      repeat (gap_len()) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Drain every expected result, idle past the tick walk, then write the register.
   task automatic write_tick_length(logic [15:0] val);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      csr_write <= 1'b1;
      csr_wdata <= val;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   function automatic logic [7:0] pick_id();
      if (known_ids.size() != 0 && $urandom_range(0, 9) < 8)
         return known_ids[$urandom_range(0, known_ids.size() - 1)];
      return 8'($urandom);
   endfunction

   // Mostly well-formed timer traffic, a little noise and undefined codes.
   task automatic random_item(logic [15:0] tl);
      int r;
      logic [15:0] el;
      logic [7:0]  tid;
      r   = $urandom_range(0, 99);
      el  = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, tl + 2));
      tid = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
      if (r < 15)
         send_item(tdt_pkg::CMD_REGISTER, tid, $urandom, 16'($urandom), 16'($urandom));
      else if (r < 23)
         send_item(tdt_pkg::CMD_REMOVE, pick_id(), $urandom, 16'($urandom), 16'($urandom));
      else if (r < 40)
         send_item(tdt_pkg::CMD_SET_SPLIT, pick_id(),
                   ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 3),
                   ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, tl)),
                   16'($urandom));
      else if (r < 55)
         send_item(tdt_pkg::CMD_SET_TOTAL, pick_id(),
                   ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 4 * tl + 3),
                   16'($urandom), 16'($urandom));
      else if (r < 95)
         send_item(tdt_pkg::CMD_TICK, 8'($urandom), $urandom, 16'($urandom), el);
      else
         send_item(3'($urandom_range(5, 7)), 8'($urandom), $urandom, 16'($urandom),
                   16'($urandom));
   endtask

   // Receiver: random stalls of mostly short length, plus a long hold-off on request.
   always @(posedge clock) begin
      if (reset || hold_off_rsp) begin
         rsp_ready <= 1'b0;
      end else if (rsp_stall != 0) begin
         rsp_ready <= 1'b0;
         rsp_stall <= rsp_stall - 1;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 2) == 0) rsp_stall <= gap_len();
      end
   end

   initial begin
      hold_off_rsp = 1'b0;
      items_sent   = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: not found, fill the table past full, every command, extremes.
      send_item(tdt_pkg::CMD_REMOVE, 8'd9, 0, 0, 0);
      for (int i = 0; i < 17; i++)
         send_item(tdt_pkg::CMD_REGISTER, (i == 16) ? 8'hFF : 8'(i), 0, 0, 0);
      send_item(tdt_pkg::CMD_SET_SPLIT, 8'd0, 32'd0, 16'd0, 0);
      send_item(tdt_pkg::CMD_SET_SPLIT, 8'd1, 32'd0, 16'd1500, 0);
      send_item(tdt_pkg::CMD_SET_SPLIT, 8'd2, 32'hFFFF_FFFF, 16'hFFFF, 0);
      send_item(tdt_pkg::CMD_SET_TOTAL, 8'd3, 32'd2500, 0, 0);
      send_item(tdt_pkg::CMD_SET_TOTAL, 8'd4, 32'd1000, 0, 0);
      send_item(tdt_pkg::CMD_TICK, 0, 0, 0, 16'hFFFF);
      send_item(tdt_pkg::CMD_TICK, 0, 0, 0, 16'd0);
      send_item(3'd7, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
      send_item(tdt_pkg::CMD_REMOVE, 8'd0, 0, 0, 0);

      // Pressure: hold the receiver off while many expiries pile up.
      for (int i = 1; i < 14; i++) send_item(tdt_pkg::CMD_SET_SPLIT, 8'(i), 32'd0, 16'd1, 0);
      fork
         begin
            hold_off_rsp = 1'b1;
            repeat (200) @(posedge clock);
            hold_off_rsp = 1'b0;
         end
         begin
            send_item(tdt_pkg::CMD_TICK, 0, 0, 0, 16'd5);
            send_item(tdt_pkg::CMD_REGISTER, 8'd77, 0, 0, 0);
            send_item(tdt_pkg::CMD_REMOVE, 8'd77, 0, 0, 0);
         end
      join

      // Random phases across several tick lengths, extremes included.
      begin
         logic [15:0] lengths[5];
         lengths = '{16'd0, 16'd1, 16'd65535, 16'd7, 16'd1000};
         for (int p = 0; p < 5; p++) begin
            write_tick_length(lengths[p]);
            for (int j = 0; j < 47; j++)
               random_item((lengths[p] == 0) ? 16'd1 :
                           ((lengths[p] > 4000) ? 16'd4000 : lengths[p]));
         end
      end
      req_valid <= 1'b0;

      // Wait out the results, then the block's longest walk.
      while (pending_count != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("Sent %0d command items over five tick lengths; %0d expiry results seen.",
               items_sent, expiry_count);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #10ms;
      $display("Timeout");
      $display("Simulation FAILED");
      $finish;
   end

endmodule
